@@ rtl/core/range_min_segment_tree_top_defines.svh @@
// Assertion macros used by the range-minimum segment tree top level.
`ifndef RANGE_MIN_SEGMENT_TREE_TOP_DEFINES_SVH
`define RANGE_MIN_SEGMENT_TREE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// The condition must never hold outside reset.
`define RMST_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("rmst: forbidden condition seen");
// When the antecedent holds, the consequent must hold in the next cycle.
`define RMST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rmst: expected follow-up did not occur");
`else
`define RMST_ASSERT_NEVER(lbl, cond)
`define RMST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/rmst_pkg.sv @@
// Constants and types shared by the range-minimum segment tree modules.
package rmst_pkg;

    // Tree geometry.
    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_WIDTH  = 32;
    localparam int LEVELS       = $clog2(MAX_ELEMENTS);
    localparam int NODE_COUNT   = 2 * MAX_ELEMENTS - 1;
    localparam int AW           = $clog2(NODE_COUNT);
    // One-based node numbers reach 2 * MAX_ELEMENTS as an exclusive bound.
    localparam int NW           = LEVELS + 2;

    // Fixed field widths.
    localparam int IDX_W = 10;
    localparam int LEN_W = 11;
    localparam int OUT_W = 32;

    // Keys carry the value with its sign bit flipped, so unsigned order is signed order.
    localparam logic [VALUE_WIDTH-1:0] KEY_SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] KEY_MAX  = {VALUE_WIDTH{1'b1}};

    // Request payload as seen by the datapath.
    typedef struct packed {
        logic                    req_type;
        logic [IDX_W-1:0]        elem_index;
        logic signed [OUT_W-1:0] elem_value;
        logic [IDX_W-1:0]        range_low;
        logic [IDX_W-1:0]        range_high;
    } t_req;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic u_leaf;
        logic u_rd;
        logic u_up;
        logic q_l;
        logic q_r;
        logic q_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic upd_ok;
        logic q_empty;
        logic at_root;
        logic l_lt_r;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/core/rmst_ifs.sv @@
// Request and response channel interfaces of the range-minimum segment tree.
interface rmst_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic [rmst_pkg::IDX_W-1:0]        elem_index;
    logic signed [rmst_pkg::OUT_W-1:0] elem_value;
    logic [rmst_pkg::IDX_W-1:0]        range_low;
    logic [rmst_pkg::IDX_W-1:0]        range_high;

    modport source (
        output valid, req_type, elem_index, elem_value, range_low, range_high,
        input  ready
    );
    modport sink (
        input  valid, req_type, elem_index, elem_value, range_low, range_high,
        output ready
    );
endinterface

interface rmst_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [rmst_pkg::OUT_W-1:0] min_value;

    modport source (output valid, min_value, input ready);
    modport sink (input valid, min_value, output ready);
endinterface

@@ rtl/core/rmst_ctrl.sv @@
// Sequencer for clearing, element updates and range queries of the tree.
module rmst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  rmst_pkg::t_sts i_sts,
    output logic           o_ready,
    output rmst_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        ST_CLR    = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_U_LEAF = 8'b0000_0100,
        ST_U_RD   = 8'b0000_1000,
        ST_U_UP   = 8'b0001_0000,
        ST_Q_L    = 8'b0010_0000,
        ST_Q_R    = 8'b0100_0000,
        ST_Q_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.is_query) begin
                        n_state = i_sts.q_empty ? ST_Q_OUT : ST_Q_L;
                    end else begin
                        n_state = i_sts.upd_ok ? ST_U_LEAF : ST_IDLE;
                    end
                end
            end
            ST_U_LEAF: begin
                o_cmd.u_leaf = 1'b1;
                n_state      = ST_U_RD;
            end
            ST_U_RD: begin
                if (i_sts.at_root) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.u_rd = 1'b1;
                    n_state    = ST_U_UP;
                end
            end
            ST_U_UP: begin
                o_cmd.u_up = 1'b1;
                n_state    = ST_U_RD;
            end
            ST_Q_L: begin
                if (i_sts.l_lt_r) begin
                    o_cmd.q_l = 1'b1;
                    n_state   = ST_Q_R;
                end else begin
                    n_state = ST_Q_OUT;
                end
            end
            ST_Q_R: begin
                o_cmd.q_r = 1'b1;
                n_state   = ST_Q_L;
            end
            ST_Q_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.q_out = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/rmst_datapath.sv @@
// Node memory, walk registers, accumulator and result register of the tree.
module rmst_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rmst_pkg::LEN_W-1:0]         i_cfg_data,
    input  rmst_pkg::t_req                     i_req,
    input  rmst_pkg::t_cmd                     i_cmd,
    input  logic                               i_rsp_ready,
    output rmst_pkg::t_sts                     o_sts,
    output logic                               o_rsp_valid,
    output logic signed [rmst_pkg::OUT_W-1:0]  o_min_value
);

    localparam int VW = rmst_pkg::VALUE_WIDTH;
    localparam int NW = rmst_pkg::NW;
    localparam int AW = rmst_pkg::AW;
    localparam int LW = rmst_pkg::LEN_W;

    // One-based node number to memory address.
    function automatic logic [AW-1:0] node_addr(input logic [NW-1:0] node);
        logic [NW-1:0] tmp;
        tmp = node - NW'(1);
        return tmp[AW-1:0];
    endfunction

    function automatic logic [VW-1:0] key_min(input logic [VW-1:0] a,
                                              input logic [VW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    logic [VW-1:0] r_mem [0:rmst_pkg::NODE_COUNT-1];

    logic [LW-1:0]        r_used_len;
    logic [AW-1:0]        r_clr_cnt;
    logic [NW-1:0]        r_pos;
    logic [NW-1:0]        r_l;
    logic [NW-1:0]        r_r;
    logic [VW-1:0]        r_acc;
    logic [VW-1:0]        r_rdata;
    logic                 r_acc_en;
    logic                 r_out_vld;
    logic [rmst_pkg::OUT_W-1:0] r_out_data;

    logic [LW-1:0]        w_len;
    logic [LW-1:0]        w_hi_clip;
    logic [VW-1:0]        w_key_in;
    logic [VW-1:0]        w_up_min;
    logic signed [VW-1:0] w_out_s;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [VW-1:0]        w_wdata;
    logic                 w_re;
    logic [AW-1:0]        w_raddr;

    // Length in use, clipped to the tree size, and the query's high bound clipped to that length.
    always_comb begin
        if (32'(r_used_len) > 32'(rmst_pkg::MAX_ELEMENTS)) begin
            w_len = LW'(rmst_pkg::MAX_ELEMENTS);
        end else begin
            w_len = r_used_len;
        end
        if (LW'(i_req.range_high) >= w_len) begin
            w_hi_clip = w_len - LW'(1);
        end else begin
            w_hi_clip = LW'(i_req.range_high);
        end
    end

    assign w_key_in = VW'($unsigned(i_req.elem_value)) ^ rmst_pkg::KEY_SIGN;
    assign w_up_min = key_min(r_acc, r_rdata);
    assign w_out_s  = $signed(r_acc ^ rmst_pkg::KEY_SIGN);

    // Status toward the controller.
    always_comb begin
        o_sts.clr_last = (r_clr_cnt == AW'(rmst_pkg::NODE_COUNT - 1));
        o_sts.is_query = i_req.req_type;
        o_sts.upd_ok   = (LW'(i_req.elem_index) < w_len);
        o_sts.q_empty  = (w_len == '0) || (LW'(i_req.range_low) > w_hi_clip);
        o_sts.at_root  = (r_pos == NW'(1));
        o_sts.l_lt_r   = (r_l < r_r);
        o_sts.out_free = !r_out_vld || i_rsp_ready;
    end

    // Node memory port selection; the sequencer never overlaps users.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr_cnt;
        w_wdata = rmst_pkg::KEY_MAX;
        w_re    = 1'b0;
        w_raddr = node_addr(r_l);
        priority if (i_cmd.clr_wr) begin
            w_we = 1'b1;
        end else if (i_cmd.u_leaf) begin
            w_we    = 1'b1;
            w_waddr = node_addr(r_pos);
            w_wdata = r_acc;
        end else if (i_cmd.u_up) begin
            w_we    = 1'b1;
            w_waddr = node_addr(r_pos >> 1);
            w_wdata = w_up_min;
        end else begin
            w_we = 1'b0;
        end
        priority if (i_cmd.u_rd) begin
            w_re    = 1'b1;
            w_raddr = node_addr(r_pos ^ NW'(1));
        end else if (i_cmd.q_l) begin
            w_re    = r_l[0];
            w_raddr = node_addr(r_l);
        end else if (i_cmd.q_r) begin
            w_re    = r_r[0];
            w_raddr = node_addr(r_r - NW'(1));
        end else begin
            w_re = 1'b0;
        end
    end

    // Node memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // Control registers: length register, clear counter, valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_len <= LW'(rmst_pkg::MAX_ELEMENTS);
            r_clr_cnt  <= '0;
            r_acc_en   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_used_len <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            r_acc_en <= (i_cmd.q_l && r_l[0]) || (i_cmd.q_r && r_r[0]);
            if (i_cmd.q_out) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Walk registers and running minimum.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pos <= NW'(rmst_pkg::MAX_ELEMENTS) + NW'(i_req.elem_index);
            r_l   <= NW'(rmst_pkg::MAX_ELEMENTS) + NW'(i_req.range_low);
            r_r   <= NW'(rmst_pkg::MAX_ELEMENTS) + NW'(w_hi_clip) + NW'(1);
            r_acc <= i_req.req_type ? rmst_pkg::KEY_MAX : w_key_in;
        end else if (i_cmd.u_up) begin
            r_acc <= w_up_min;
            r_pos <= r_pos >> 1;
        end else begin
            if (r_acc_en) begin
                r_acc <= w_up_min;
            end
            if (i_cmd.q_l) begin
                r_l <= r_l + NW'(r_l[0]);
            end
            if (i_cmd.q_r) begin
                r_l <= r_l >> 1;
                r_r <= r_r >> 1;
            end
        end
    end

    // Result register, sign extended from the value width.
    always_ff @(posedge i_clk) begin
        if (i_cmd.q_out) begin
            r_out_data <= rmst_pkg::OUT_W'(w_out_s);
        end
    end

    assign o_rsp_valid = r_out_vld;
    assign o_min_value = $signed(r_out_data);

endmodule

@@ rtl/core/range_min_segment_tree_top.sv @@
// Top level of the range-minimum segment tree over one single-port node memory.
// An update writes the leaf, then does a sibling read and a parent write per level.
// A query walks its bounds upward, two steps per level, and then loads its result register.
// The single node memory port serves one access per cycle; one item at a time.
// After reset a clearing pass writes every node; no request is taken meanwhile.
`include "range_min_segment_tree_top_defines.svh"
module range_min_segment_tree_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rmst_pkg::LEN_W-1:0] i_cfg_data,
    rmst_req_if.sink                   i_req,
    rmst_rsp_if.source                 o_rsp
);

    rmst_pkg::t_req w_req;
    rmst_pkg::t_cmd w_cmd;
    rmst_pkg::t_sts w_sts;
    logic           w_ready;
    logic           w_rsp_valid;
    logic signed [rmst_pkg::OUT_W-1:0] w_min_value;

    // Request payload gathered for the datapath.
    always_comb begin
        w_req.req_type   = i_req.req_type;
        w_req.elem_index = i_req.elem_index;
        w_req.elem_value = i_req.elem_value;
        w_req.range_low  = i_req.range_low;
        w_req.range_high = i_req.range_high;
    end

    rmst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_sts   (w_sts),
        .o_ready (w_ready),
        .o_cmd   (w_cmd)
    );

    rmst_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req       (w_req),
        .i_cmd       (w_cmd),
        .i_rsp_ready (o_rsp.ready),
        .o_sts       (w_sts),
        .o_rsp_valid (w_rsp_valid),
        .o_min_value (w_min_value)
    );

    assign i_req.ready     = w_ready;
    assign o_rsp.valid     = w_rsp_valid;
    assign o_rsp.min_value = w_min_value;

    // No request transfer while the clearing pass runs.
    `RMST_ASSERT_NEVER(a_no_ready_in_clear, w_cmd.clr_wr && i_req.ready)
    // A result is loaded only into a free result register.
    `RMST_ASSERT_NEVER(a_no_result_overrun, w_cmd.q_out && !w_sts.out_free)
    // An accepted query keeps the block busy on the next cycle.
    `RMST_ASSERT_NEXT(a_query_busy, i_req.valid && i_req.ready && i_req.req_type, !i_req.ready)

endmodule
